### src/text_console_writer_macros.svh
// assertion macros shared by the console writer modules
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("console writer assertion failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("console writer assertion failed");

`endif

### src/tcw_pkg.sv
// types, codes and character tables of the console writer
package tcw_pkg;

   localparam logic [1:0] CMD_PUT = 2'd0;
   localparam logic [1:0] CMD_HEX = 2'd1;
   localparam logic [1:0] CMD_DEC = 2'd2;

   localparam logic [7:0] CHAR_NL = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   localparam logic [31:0] DEC_LIMIT = 32'd100000;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_PUT,
      FR_HEX,
      FR_DEC,
      FR_BIG
   } front_state_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } char_entry_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + {4'd0, d};
      end else begin
         c = 8'h57 + {4'd0, d};
      end
      return c;
   endfunction

   // characters of the overflow text ">=100000"
   function automatic logic [7:0] big_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h3e;
         3'd1:    c = 8'h3d;
         3'd2:    c = 8'h31;
         default: c = CHAR_ZERO;
      endcase
      return c;
   endfunction

   // k times the decimal weight of digit position pos (0 is ten thousands)
   function automatic logic [16:0] dec_weight(input logic [2:0] pos, input logic [3:0] k);
      logic [16:0] pw;
      case (pos)
         3'd0:    pw = 17'd10000;
         3'd1:    pw = 17'd1000;
         3'd2:    pw = 17'd100;
         3'd3:    pw = 17'd10;
         default: pw = 17'd1;
      endcase
      return 17'(pw * {13'd0, k});
   endfunction

endpackage

### src/text_console_writer.sv
// top level of the text console writer
//
//   channel | dir | transfer when              | contents
//   req     | in  | req_tvalid & req_tready    | command, char, value, min digits
//   rsp     | out | rsp_tvalid & rsp_tready    | screen write, echo byte, cursor
//   csr     | in  | csr_we                     | uart echo enable
//
// a command is taken when idle; then one char slot per cycle unless the queue is full:
// one for a put, eight digit slots for hex, five for decimal, eight for the overflow text
// the back gives one result per unstalled cycle, two for a character that wraps the line
// a four-entry queue lets the front run ahead while the result register is stalled
// reset is synchronous, homes the cursor and clears echo; screen memory is external
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS = 30
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // char_code, value, min_digits, unused
   input  logic [1:0]  req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // screen_offset, screen_char, uart_byte, cursor_row,
                                   // cursor_col
   output logic [1:0]  rsp_tuser,  // screen_write, uart_valid
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_wdata
);

   logic           echo_ff, echo_in;
   logic           push;
   logic           full;
   logic           pop;
   logic           empty;
   char_entry_type front_entry;
   char_entry_type queue_entry;

   logic        screen_write;
   logic [11:0] screen_offset;
   logic [7:0]  screen_char;
   logic        uart_valid;
   logic [7:0]  uart_byte;
   logic [4:0]  cursor_row;
   logic [6:0]  cursor_col;

   assign echo_in = csr_we ? csr_wdata : echo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff <= 1'b0;
      end else begin
         echo_ff <= echo_in;
      end
   end

   tcw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid_i  (req_tvalid),
      .req_ready_o  (req_tready),
      .cmd_i        (req_tuser),
      .char_code_i  (req_tdata[7:0]),
      .value_i      (req_tdata[39:8]),
      .min_digits_i (req_tdata[43:40]),
      .full_i       (full),
      .push_o       (push),
      .entry_o      (front_entry)
   );

   tcw_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (push),
      .entry_i (front_entry),
      .full_o  (full),
      .pop_i   (pop),
      .empty_o (empty),
      .entry_o (queue_entry)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .echo_i          (echo_ff),
      .empty_i         (empty),
      .entry_i         (queue_entry),
      .pop_o           (pop),
      .rsp_valid_o     (rsp_tvalid),
      .rsp_ready_i     (rsp_tready),
      .screen_write_o  (screen_write),
      .screen_offset_o (screen_offset),
      .screen_char_o   (screen_char),
      .uart_valid_o    (uart_valid),
      .uart_byte_o     (uart_byte),
      .cursor_row_o    (cursor_row),
      .cursor_col_o    (cursor_col),
      .last_o          (rsp_tlast)
   );

   assign rsp_tdata = {cursor_col, cursor_row, uart_byte, screen_char, screen_offset};
   assign rsp_tuser = {uart_valid, screen_write};

endmodule

### src/tcw_front.sv
// front end: takes commands and breaks them into a character stream
module tcw_front
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid_i,
   output logic           req_ready_o,
   input  logic [1:0]     cmd_i,
   input  logic [7:0]     char_code_i,
   input  logic [31:0]    value_i,
   input  logic [3:0]     min_digits_i,
   input  logic           full_i,
   output logic           push_o,
   output char_entry_type entry_o
);

   front_state_type state_ff, state_in;
   logic [2:0]  idx_ff, idx_in;
   logic [3:0]  lim_ff, lim_in;
   logic [31:0] value_ff, value_in;
   logic [16:0] rem_ff, rem_in;
   logic [7:0]  char_ff, char_in;

   logic        accept;
   logic        step;
   logic        done;
   logic        want;
   logic [3:0]  hex_digit;
   logic        hex_skip;
   logic [3:0]  dec_digit;

   assign accept = req_valid_i && req_ready_o;
   assign hex_digit = value_ff[{idx_ff, 2'b00} +: 4];
   assign hex_skip = (hex_digit == 4'd0) && ({1'b0, idx_ff} >= lim_ff);

   always_comb begin
      dec_digit = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem_ff >= dec_weight(idx_ff, 4'(k))) begin
            dec_digit = 4'(k);
         end
      end
   end

   // outputs
   always_comb begin
      req_ready_o = 1'b0;
      want = 1'b0;
      step = 1'b0;
      done = 1'b0;
      entry_o = '{char_code: 8'd0, last: 1'b0};
      unique case (state_ff)
         FR_IDLE: begin
            req_ready_o = 1'b1;
         end
         FR_PUT: begin
            want = 1'b1;
            step = !full_i;
            done = 1'b1;
            entry_o = '{char_code: char_ff, last: 1'b1};
         end
         FR_HEX: begin
            want = !hex_skip;
            step = hex_skip || !full_i;
            done = (idx_ff == 3'd0);
            entry_o = '{char_code: hex_char(hex_digit), last: (idx_ff == 3'd0)};
         end
         FR_DEC: begin
            want = 1'b1;
            step = !full_i;
            done = (idx_ff == 3'd4);
            entry_o = '{char_code: CHAR_ZERO + {4'd0, dec_digit}, last: (idx_ff == 3'd4)};
         end
         FR_BIG: begin
            want = 1'b1;
            step = !full_i;
            done = (idx_ff == 3'd7);
            entry_o = '{char_code: big_char(idx_ff), last: (idx_ff == 3'd7)};
         end
         default: begin
            req_ready_o = 1'b0;
         end
      endcase
      push_o = want && !full_i;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: begin
            if (accept) begin
               unique case (cmd_i)
                  CMD_PUT: state_in = FR_PUT;
                  CMD_HEX: state_in = FR_HEX;
                  CMD_DEC: state_in = (value_i >= DEC_LIMIT) ? FR_BIG : FR_DEC;
                  default: state_in = FR_IDLE;
               endcase
            end
         end
         FR_PUT, FR_HEX, FR_DEC, FR_BIG: begin
            if (step && done) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      idx_in = idx_ff;
      lim_in = lim_ff;
      value_in = value_ff;
      rem_in = rem_ff;
      char_in = char_ff;
      if (accept) begin
         idx_in = (cmd_i == CMD_HEX) ? 3'd7 : 3'd0;
         lim_in = (min_digits_i > 4'd8) ? 4'd8 : min_digits_i;
         value_in = value_i;
         rem_in = value_i[16:0];
         char_in = char_code_i;
      end else if (step) begin
         case (state_ff)
            FR_HEX: begin
               idx_in = idx_ff - 3'd1;
               if (!hex_skip) begin
                  lim_in = {1'b0, idx_ff};
               end
            end
            FR_DEC: begin
               idx_in = idx_ff + 3'd1;
               rem_in = rem_ff - dec_weight(idx_ff, dec_digit);
            end
            FR_BIG: begin
               idx_in = idx_ff + 3'd1;
            end
            default: begin
               idx_in = idx_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      lim_ff <= lim_in;
      value_ff <= value_in;
      rem_ff <= rem_in;
      char_ff <= char_in;
   end

endmodule

### src/tcw_fifo.sv
// short character queue between front and back ends
`include "text_console_writer_macros.svh"
module tcw_fifo
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push_i,
   input  char_entry_type entry_i,
   output logic           full_o,
   input  logic           pop_i,
   output logic           empty_o,
   output char_entry_type entry_o
);

   char_entry_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]      count_ff, count_in;

   assign full_o = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign empty_o = (count_ff == '0);
   assign entry_o = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_i ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_i ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push_i && !pop_i) begin
         count_in = count_ff + 1'b1;
      end else if (pop_i && !push_i) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push_i) begin
         slot_ff[wr_ptr_ff] <= entry_i;
      end
   end

   `TCW_ASSERT_NOW(a_no_overflow, clock, reset, push_i, !full_o)
   `TCW_ASSERT_NOW(a_no_underflow, clock, reset, pop_i, !empty_o)

endmodule

### src/tcw_back.sv
// back end: cursor, screen addressing, echo and result register
`include "text_console_writer_macros.svh"
module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS = 30
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           echo_i,
   input  logic           empty_i,
   input  char_entry_type entry_i,
   output logic           pop_o,
   output logic           rsp_valid_o,
   input  logic           rsp_ready_i,
   output logic           screen_write_o,
   output logic [11:0]    screen_offset_o,
   output logic [7:0]     screen_char_o,
   output logic           uart_valid_o,
   output logic [7:0]     uart_byte_o,
   output logic [4:0]     cursor_row_o,
   output logic [6:0]     cursor_col_o,
   output logic           last_o
);

   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);

   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             pend_ff, pend_in;
   logic [7:0]       pend_char_ff, pend_char_in;
   logic             pend_last_ff, pend_last_in;

   logic             valid_ff, valid_in;
   logic             sw_ff, sw_in;
   logic [11:0]      off_ff, off_in;
   logic [7:0]       char_ff, char_in;
   logic             uv_ff, uv_in;
   logic [7:0]       ub_ff, ub_in;
   logic [4:0]       crow_ff, crow_in;
   logic [6:0]       ccol_ff, ccol_in;
   logic             last_ff, last_in;

   logic             out_free;
   logic [ROW_W-1:0] row_wrap;
   logic [COL_W:0]   col_inc;
   logic             wrap;
   logic [15:0]      offset_full;
   logic [7:0]       echo_byte;
   logic [15:0]      row_ext;
   logic [15:0]      col_ext;

   assign out_free = !valid_ff || rsp_ready_i;
   assign pop_o = !empty_i && out_free && !pend_ff;
   assign row_wrap = (row_ff == ROW_W'(ROWS - 1)) ? '0 : row_ff + 1'b1;
   assign col_inc = {1'b0, col_ff} + 1'b1;
   assign wrap = (entry_i.char_code != CHAR_NL) && (entry_i.char_code != CHAR_CR)
                 && (col_inc >= (COL_W + 1)'(COLUMNS));
   assign offset_full = 16'(16'(row_ff) * 16'(COLUMNS)) + 16'(col_ff);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      pend_in = pend_ff;
      pend_char_in = pend_char_ff;
      pend_last_in = pend_last_ff;
      valid_in = valid_ff && !rsp_ready_i;
      sw_in = sw_ff;
      off_in = off_ff;
      char_in = char_ff;
      echo_byte = 8'd0;
      last_in = last_ff;
      if (pop_o) begin
         valid_in = 1'b1;
         sw_in = 1'b0;
         off_in = 12'd0;
         char_in = 8'd0;
         last_in = entry_i.last;
         if (entry_i.char_code == CHAR_NL) begin
            row_in = row_wrap;
            col_in = '0;
            echo_byte = CHAR_NL;
         end else if (entry_i.char_code == CHAR_CR) begin
            col_in = '0;
            echo_byte = CHAR_CR;
         end else begin
            sw_in = 1'b1;
            off_in = offset_full[11:0];
            char_in = entry_i.char_code;
            if (wrap) begin
               row_in = row_wrap;
               col_in = '0;
               echo_byte = CHAR_NL;
               last_in = 1'b0;
               pend_in = 1'b1;
               pend_char_in = entry_i.char_code;
               pend_last_in = entry_i.last;
            end else begin
               col_in = col_inc[COL_W-1:0];
               echo_byte = entry_i.char_code;
            end
         end
      end else if (pend_ff && out_free) begin
         valid_in = 1'b1;
         sw_in = 1'b0;
         off_in = 12'd0;
         char_in = 8'd0;
         echo_byte = pend_char_ff;
         last_in = pend_last_ff;
         pend_in = 1'b0;
      end
      row_ext = 16'(row_in);
      col_ext = 16'(col_in);
      if (pop_o || (pend_ff && out_free)) begin
         uv_in = echo_i;
         ub_in = echo_i ? echo_byte : 8'd0;
         crow_in = row_ext[4:0];
         ccol_in = col_ext[6:0];
      end else begin
         uv_in = uv_ff;
         ub_in = ub_ff;
         crow_in = crow_ff;
         ccol_in = ccol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         pend_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
         pend_ff <= pend_in;
         valid_ff <= valid_in;
      end
      pend_char_ff <= pend_char_in;
      pend_last_ff <= pend_last_in;
      sw_ff <= sw_in;
      off_ff <= off_in;
      char_ff <= char_in;
      uv_ff <= uv_in;
      ub_ff <= ub_in;
      crow_ff <= crow_in;
      ccol_ff <= ccol_in;
      last_ff <= last_in;
   end

   assign rsp_valid_o = valid_ff;
   assign screen_write_o = sw_ff;
   assign screen_offset_o = off_ff;
   assign screen_char_o = char_ff;
   assign uart_valid_o = uv_ff;
   assign uart_byte_o = ub_ff;
   assign cursor_row_o = crow_ff;
   assign cursor_col_o = ccol_ff;
   assign last_o = last_ff;

   `TCW_ASSERT_NOW(a_wrap_first_half, clock, reset, pend_ff, valid_ff && sw_ff && !last_ff)
   `TCW_ASSERT_NEXT(a_wrap_pending, clock, reset, pop_o && wrap, pend_ff)
   `TCW_ASSERT_NOW(a_cursor_range, clock, reset, 1'b1,
      (32'(col_ff) < COLUMNS) && (32'(row_ff) < ROWS))

endmodule
